@@ sv/rhw_pkg.sv @@
package rhw_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int SLOT_W = $clog2(MAX_DEPTH);
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_NACK = 2'd1;
	localparam logic [1:0] ACT_BEAT = 2'd2;

	localparam logic [1:0] REG_HISTORY_DEPTH = 2'd0;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
	localparam logic [1:0] REG_OWN_WRITER_ID = 2'd2;

	localparam logic [5:0] HISTORY_DEPTH_RST = 6'd32;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd2;
	localparam logic [31:0] OWN_WRITER_ID_RST = 32'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] req_writer_id;
		logic [63:0] req_seq;
	} req_item_t;

	typedef struct packed {
		logic [63:0] seq_first;
		logic [63:0] seq_last;
		logic [4:0] slot_index;
		logic grant;
		logic [3:0] retry_count;
		logic [31:0] beat_count;
	} rsp_item_t;

	// Item after the front end has decoded it.
	typedef struct packed {
		logic [1:0] action;
		logic id_match;
		logic [63:0] req_seq;
	} cls_item_t;

	typedef struct packed {
		logic [5:0] history_depth;
		logic [3:0] retry_limit;
	} back_cfg_t;

endpackage

@@ sv/rhw_ram.sv @@
module rhw_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/rhw_front.sv @@
module rhw_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input rhw_pkg::req_item_t req,
	input logic [31:0] own_writer_id,
	input logic q_full,
	output logic push,
	output rhw_pkg::cls_item_t push_item
);
	import rhw_pkg::*;

	logic valid_s1;
	cls_item_t item_s1;
	logic take;

	assign push = valid_s1 && !q_full;
	assign req_stall = valid_s1 && q_full;
	assign take = req_valid && !req_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action <= req.action;
			item_s1.id_match <= (req.req_writer_id == own_writer_id);
			item_s1.req_seq <= req.req_seq;
		end
	end

endmodule

@@ sv/rhw_queue.sv @@
module rhw_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input rhw_pkg::cls_item_t push_item,
	input logic pop,
	output rhw_pkg::cls_item_t head,
	output logic full,
	output logic empty
);
	import rhw_pkg::*;

	cls_item_t slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0] count_q;

	assign full = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ sv/rhw_back.sv @@
module rhw_back (
	input logic clk,
	input logic arst_n,
	input rhw_pkg::back_cfg_t cfg,
	input rhw_pkg::cls_item_t head,
	input logic q_empty,
	output logic pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output rhw_pkg::rsp_item_t rsp
);
	import rhw_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic state_q;
	logic state_d;
	logic [63:0] next_seq_q;
	logic [5:0] occ_q;
	logic [31:0] beat_q;
	logic hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic rsp_valid_q;
	rsp_item_t rsp_q;

	logic out_free;
	logic load;
	rsp_item_t rsp_d;
	logic do_send;
	logic do_beat;
	logic [5:0] eff_depth;
	logic [5:0] occ_inc;
	logic [5:0] occ_d;
	logic [63:0] seq_gap;
	logic hit_now;
	logic ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [3:0] ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;
	logic [3:0] ram_rdata;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign eff_depth = (cfg.history_depth > 6'(MAX_DEPTH)) ? 6'(MAX_DEPTH) : cfg.history_depth;
	assign occ_inc = occ_q + 6'd1;
	assign seq_gap = next_seq_q - head.req_seq;
	assign hit_now = head.id_match && (seq_gap != 64'd0) && (seq_gap <= {58'd0, occ_q});
	assign ram_raddr = (state_q == ST_IDLE) ? head.req_seq[SLOT_W-1:0] : slot_q;

	always_comb begin
		pop = 1'b0;
		load = 1'b0;
		do_send = 1'b0;
		do_beat = 1'b0;
		state_d = state_q;
		rsp_d = '0;
		occ_d = occ_q;
		ram_we = 1'b0;
		ram_waddr = next_seq_q[SLOT_W-1:0];
		ram_wdata = 4'd0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (head.action == ACT_NACK) begin
						// The counter read is issued now; ST_LOOK re-reads the slot and uses the data when the output is free.
						pop = 1'b1;
						state_d = ST_LOOK;
					end else if (out_free) begin
						pop = 1'b1;
						load = 1'b1;
						case (head.action)
							ACT_SEND: begin
								do_send = 1'b1;
								rsp_d.seq_first = next_seq_q;
								if (eff_depth == 6'd0) begin
									occ_d = 6'd0;
								end else begin
									ram_we = 1'b1;
									rsp_d.slot_index = next_seq_q[SLOT_W-1:0];
									occ_d = (occ_inc > eff_depth) ? eff_depth : occ_inc;
								end
							end
							ACT_BEAT: begin
								do_beat = 1'b1;
								rsp_d.seq_first = next_seq_q - {58'd0, occ_q};
								rsp_d.seq_last = (next_seq_q > 64'd1) ? next_seq_q - 64'd1 : 64'd0;
								rsp_d.beat_count = beat_q;
							end
							default: begin
								rsp_d = '0;
							end
						endcase
					end
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					load = 1'b1;
					state_d = ST_IDLE;
					if (hit_q) begin
						rsp_d.retry_count = ram_rdata;
						if (ram_rdata < cfg.retry_limit) begin
							ram_we = 1'b1;
							ram_waddr = slot_q;
							ram_wdata = ram_rdata + 4'd1;
							rsp_d.grant = 1'b1;
							rsp_d.slot_index = slot_q;
							rsp_d.retry_count = ram_rdata + 4'd1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_seq_q <= 64'd1;
			occ_q <= 6'd0;
			beat_q <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q <= occ_d;
			if (do_send) begin
				next_seq_q <= next_seq_q + 64'd1;
			end
			if (do_beat) begin
				beat_q <= beat_q + 32'd1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop) begin
			hit_q <= hit_now;
			slot_q <= head.req_seq[SLOT_W-1:0];
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	rhw_ram #(
		.WIDTH(4),
		.DEPTH(MAX_DEPTH)
	) u_retry_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 6'(MAX_DEPTH))
		else $error("window occupancy above maximum depth");

	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.grant) |-> (rsp_q.retry_count != 4'd0))
		else $error("granted retransmit with zero retry count");

	a_look_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && ram_we) |-> hit_q)
		else $error("retry counter written for a sample not in the window");

	a_look_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !pop)
		else $error("queue popped while a nack lookup is in progress");
`endif

endmodule

@@ sv/retransmit_history_window.sv @@
// Items pass the front register, the queue and the result register; a nack also passes the
// lookup state. Throughput: one send or heartbeat item per cycle when not stalled; a nack
// holds the back end for the read-modify-write of its retry counter in the registered-read RAM.
// Reset: next sequence 1, window empty, heartbeat count 0, registers at their defaults.
// The retry counter RAM is not cleared; every held entry is written by its send first.
module retransmit_history_window (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input rhw_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rhw_pkg::rsp_item_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import rhw_pkg::*;

	logic [5:0] history_depth_q;
	logic [3:0] retry_limit_q;
	logic [31:0] own_writer_id_q;
	back_cfg_t back_cfg;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cls_item_t push_item;
	cls_item_t head;

	assign cfg_ready = 1'b1;
	assign back_cfg.history_depth = history_depth_q;
	assign back_cfg.retry_limit = retry_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_depth_q <= HISTORY_DEPTH_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
			own_writer_id_q <= OWN_WRITER_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HISTORY_DEPTH: history_depth_q <= cfg_data[5:0];
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				REG_OWN_WRITER_ID: own_writer_id_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rhw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.own_writer_id(own_writer_id_q),
		.q_full(q_full),
		.push(push),
		.push_item(push_item)
	);

	rhw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	rhw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(back_cfg),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule

@@ bench/retransmit_history_window_checker.sv @@
module retransmit_history_window_checker
	import rhw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_item_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_item_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	output int mismatches,
	output int rsp_owed,
	output int rsp_checked,
	output int grants
);

	// Shadow copy of the registers and of the window state.
	logic [5:0] depth_reg;
	logic [3:0] limit_reg;
	logic [31:0] writer_reg;
	logic [63:0] next_seq;
	logic [5:0] held;
	logic [3:0] retries [MAX_DEPTH];
	logic [31:0] beats;

	rsp_item_t owed_rsp [$];
	rsp_item_t want_rsp;

	function automatic rsp_item_t history_outcome(input req_item_t r);
		rsp_item_t o;
		logic [5:0] eff;
		logic [63:0] seq_gap;
		logic [SLOT_W-1:0] s;
		logic [3:0] c;
		o = '0;
		eff = (depth_reg > MAX_DEPTH) ? 6'(MAX_DEPTH) : depth_reg;
		case (r.action)
			ACT_SEND: begin
				o.seq_first = next_seq;
				if (eff == 6'd0) begin
					held = 6'd0;
				end else begin
					s = SLOT_W'(next_seq % MAX_DEPTH);
					retries[s] = 4'd0;
					held = (held + 6'd1 > eff) ? eff : held + 6'd1;
					o.slot_index = s;
				end
				next_seq = next_seq + 64'd1;
			end
			ACT_NACK: begin
				seq_gap = next_seq - r.req_seq;
				if (r.req_writer_id == writer_reg && seq_gap >= 64'd1
						&& seq_gap <= 64'(held)) begin
					s = SLOT_W'(r.req_seq % MAX_DEPTH);
					c = retries[s];
					if (c < limit_reg) begin
						c = c + 4'd1;
						retries[s] = c;
						o.slot_index = s;
						o.grant = 1'b1;
					end
					o.retry_count = c;
				end
			end
			ACT_BEAT: begin
				o.seq_first = (held == 6'd0) ? next_seq : next_seq - 64'(held);
				o.seq_last = (next_seq > 64'd1) ? next_seq - 64'd1 : 64'd0;
				o.beat_count = beats;
				beats = beats + 32'd1;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_reg = HISTORY_DEPTH_RST;
			limit_reg = RETRY_LIMIT_RST;
			writer_reg = OWN_WRITER_ID_RST;
			next_seq = 64'd1;
			held = 6'd0;
			beats = 32'd0;
			foreach (retries[i]) retries[i] = 4'd0;
			owed_rsp.delete();
			mismatches = 0;
			rsp_checked = 0;
			grants = 0;
			rsp_owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HISTORY_DEPTH: depth_reg = cfg_data[5:0];
					REG_RETRY_LIMIT: limit_reg = cfg_data[3:0];
					REG_OWN_WRITER_ID: writer_reg = cfg_data;
					default: begin
					end
				endcase
			end
			if (req_valid && !req_stall) begin
				want_rsp = history_outcome(req);
				if (want_rsp.grant) grants++;
				owed_rsp.push_back(want_rsp);
			end
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					$display("%0t: result with no item outstanding, expected none, got %0h",
						$time, rsp);
					mismatches++;
				end else begin
					want_rsp = owed_rsp.pop_front();
					check_field("seq_first", want_rsp.seq_first, rsp.seq_first);
					check_field("seq_last", want_rsp.seq_last, rsp.seq_last);
					check_field("slot_index", 64'(want_rsp.slot_index),
						64'(rsp.slot_index));
					check_field("grant", 64'(want_rsp.grant), 64'(rsp.grant));
					check_field("retry_count", 64'(want_rsp.retry_count),
						64'(rsp.retry_count));
					check_field("beat_count", 64'(want_rsp.beat_count),
						64'(rsp.beat_count));
					rsp_checked++;
				end
			end
			rsp_owed = owed_rsp.size();
		end
	end

endmodule

@@ bench/retransmit_history_window_tb.sv @@
module retransmit_history_window_tb;
	import rhw_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 10;
	localparam int LONG_HOLD = 300;
	localparam int SEGMENTS = 8;
	localparam int SEG_ITEMS = 125;
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int mismatches;
	int rsp_owed;
	int rsp_checked;
	int grants;

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	logic [63:0] seq_next = 64'd1;
	logic [31:0] writer_id = OWN_WRITER_ID_RST;

	logic [5:0] seg_depth [SEGMENTS];
	logic [3:0] seg_limit [SEGMENTS];
	logic [31:0] seg_writer [SEGMENTS];

	retransmit_history_window dut (.*);

	retransmit_history_window_checker u_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver stalls at random, or for a long stretch when the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet + 1 >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results still owed",
				$time, QUIET_LIMIT, rsp_owed);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic req_item_t req_of(input logic [1:0] action, input logic [31:0] wid,
			input logic [63:0] seq);
		req_item_t r;
		r.action = action;
		r.req_writer_id = wid;
		r.req_seq = seq;
		return r;
	endfunction

	// Mostly sends and nacks aimed at the recent window, with some noise.
	function automatic req_item_t random_req();
		req_item_t r;
		int pick;
		r = req_of(ACT_SEND, $urandom, {$urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 38) begin
			r.action = ACT_SEND;
		end else if (pick < 75) begin
			r.action = ACT_NACK;
			r.req_writer_id = writer_id;
			r.req_seq = seq_next - 64'($urandom_range(1, 34));
		end else if (pick < 87) begin
			r.action = ACT_BEAT;
		end else if (pick < 92) begin
			r.action = ACT_NACK;
			r.req_writer_id = writer_id ^ (32'd1 << $urandom_range(31));
			r.req_seq = seq_next - 64'($urandom_range(1, 3));
		end else if (pick < 97) begin
			r.action = ACT_NACK;
		end else begin
			r.action = ACT_NONE;
		end
		return r;
	endfunction

	task automatic offer(input req_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		if (item.action == ACT_SEND) seq_next = seq_next + 64'd1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (rsp_owed != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Upper data bits are filled at random; the narrow registers must ignore them.
	task automatic configure(input logic [5:0] depth, input logic [3:0] limit,
			input logic [31:0] wid);
		write_reg(REG_HISTORY_DEPTH, ($urandom & ~32'h3F) | 32'(depth));
		write_reg(REG_RETRY_LIMIT, ($urandom & ~32'hF) | 32'(limit));
		write_reg(REG_OWN_WRITER_ID, wid);
		writer_id = wid;
	endtask

	initial begin
		req_item_t item;
		int n;
		seg_depth = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd5, 6'd33, 6'd2, 6'd31};
		seg_limit = '{4'd2, 4'd15, 4'd0, 4'd1, 4'd3, 4'd15, 4'd7, 4'd4};
		seg_writer = '{32'd2, 32'hFFFF_FFFF, 32'd0, $urandom, $urandom, 32'h8000_0001,
			$urandom, 32'd2};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers at their reset values: empty window, limit reached, foreign id,
		// samples not held, out-of-range sequences and the unused action.
		offer(req_of(ACT_BEAT, 32'd0, 64'd0));
		offer(req_of(ACT_NACK, 32'd2, 64'd1));
		offer(req_of(ACT_SEND, 32'd0, 64'd0));
		offer(req_of(ACT_SEND, 32'hFFFF_FFFF, '1));
		offer(req_of(ACT_BEAT, 32'd0, 64'd0));
		repeat (3) offer(req_of(ACT_NACK, 32'd2, 64'd1));
		offer(req_of(ACT_NACK, 32'd3, 64'd2));
		offer(req_of(ACT_NACK, 32'd2, 64'd3));
		offer(req_of(ACT_NACK, 32'hFFFF_FFFF, '1));
		offer(req_of(ACT_NONE, 32'hFFFF_FFFF, '1));
		drain();

		// A lowered depth only trims the window at the next send.
		write_reg(REG_HISTORY_DEPTH, 32'd1);
		offer(req_of(ACT_BEAT, 32'd0, 64'd0));
		offer(req_of(ACT_NACK, 32'd2, 64'd1));
		offer(req_of(ACT_SEND, 32'd0, 64'd0));
		offer(req_of(ACT_NACK, 32'd2, 64'd2));
		offer(req_of(ACT_BEAT, 32'd0, 64'd0));
		drain();

		// Depth zero empties the window on a send.
		write_reg(REG_HISTORY_DEPTH, 32'd0);
		offer(req_of(ACT_SEND, 32'd0, 64'd0));
		offer(req_of(ACT_BEAT, 32'd0, 64'd0));
		offer(req_of(ACT_NACK, 32'd2, 64'd4));
		drain();

		// Depth beyond the window size, a zero limit and a zero writer id.
		configure(6'd63, 4'd0, 32'd0);
		offer(req_of(ACT_SEND, 32'd0, 64'd0));
		offer(req_of(ACT_NACK, 32'd0, 64'd5));
		offer(req_of(ACT_BEAT, 32'd0, 64'd0));
		drain();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			configure(seg_depth[seg], seg_limit[seg], seg_writer[seg]);
			if (seg == 4) write_reg(REG_SPARE, $urandom);
			case (seg % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 74; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 74; end
				default: begin gap_pct = 31; stall_pct = 31; end
			endcase
			n = 0;
			while (n < SEG_ITEMS) begin
				item = random_req();
				if (seg == 0 && n == 40) hold_trigger++;
				offer(item);
				if (item.action != ACT_NONE) n++;
			end
			drain();
		end

		$display("Checked %0d results, %0d of them granted retransmits, over %0d settings",
			rsp_checked, grants, SEGMENTS + 4);
		$display("of depth, retry limit and writer id, under four patterns of idling.");
		if (mismatches == 0 && rsp_owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ retransmit_history_window.f @@
sv/rhw_pkg.sv
sv/rhw_ram.sv
sv/rhw_front.sv
sv/rhw_queue.sv
sv/rhw_back.sv
sv/retransmit_history_window.sv
bench/retransmit_history_window_checker.sv
bench/retransmit_history_window_tb.sv
